// ===== sv/threshold_network_sync_update_defines.svh =====
// assertion macros for the checker file
`ifndef THRESHOLD_NETWORK_SYNC_UPDATE_DEFINES_SVH
`define THRESHOLD_NETWORK_SYNC_UPDATE_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define TNSU_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tnsu check failed");

// next-cycle implication
`define TNSU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tnsu check failed");

// delayed implication
`define TNSU_ASSERT_AFTER2(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##2 (cons)) \
      else $error("tnsu check failed");

`endif

// ===== sv/tnsu_pkg.sv =====
package tnsu_pkg;

   // sizes
   localparam int NODES      = 64;
   localparam int STATE_W    = 64;
   localparam int NODE_W     = 6;
   localparam int THR_W      = 8;
   localparam int WEIGHT_W   = 2;
   localparam int REQ_W      = 2;
   localparam int NODE_IDX_W = $clog2(NODES);
   localparam int ROW_W      = NODES * WEIGHT_W;
   localparam int GRP        = 8;
   localparam int GROUPS     = (NODES + GRP - 1) / GRP;
   localparam int GRP_CNT_W  = $clog2(GRP + 1);
   localparam int CNT_W      = $clog2(NODES + 1);
   localparam int CMP_W      = (CNT_W + 1 > THR_W) ? CNT_W + 1 : THR_W;

   localparam logic [NODE_IDX_W-1:0] LAST_NODE = NODE_IDX_W'(NODES - 1);
   localparam logic [STATE_W-1:0]    NODE_MASK = STATE_W'({NODES{1'b1}});

   // weight codes
   localparam logic [WEIGHT_W-1:0] W_NEG_SAT = 2'b10;
   localparam logic [WEIGHT_W-1:0] W_MINUS   = 2'b11;

   // request codes
   typedef enum logic [REQ_W-1:0] {
      REQ_WRITE = 2'd0,
      REQ_LOAD  = 2'd1,
      REQ_STEP  = 2'd2
   } req_code_type;

   // microprogram addresses
   typedef enum logic [3:0] {
      UPC_CLEAR   = 4'd0,
      UPC_IDLE    = 4'd1,
      UPC_WR_RD   = 4'd2,
      UPC_WR_MOD  = 4'd3,
      UPC_LOAD    = 4'd4,
      UPC_REPLY   = 4'd5,
      UPC_STEP    = 4'd6,
      UPC_DRAIN_A = 4'd7,
      UPC_DRAIN_B = 4'd8,
      UPC_COMMIT  = 4'd9
   } upc_type;

   typedef enum logic [2:0] {
      RAM_NONE     = 3'd0,
      RAM_CLEAR    = 3'd1,
      RAM_READ_DST = 3'd2,
      RAM_MERGE    = 3'd3,
      RAM_READ_CNT = 3'd4
   } ram_op_type;

   typedef enum logic [1:0] {
      ST_HOLD   = 2'd0,
      ST_LOAD   = 2'd1,
      ST_COMMIT = 2'd2
   } state_op_type;

   typedef enum logic [1:0] {
      SEQ_GOTO     = 2'd0,
      SEQ_LOOP     = 2'd1,
      SEQ_DISPATCH = 2'd2
   } seq_type;

   typedef struct packed {
      logic         busy;
      ram_op_type   ram_op;
      logic         cnt_step;
      state_op_type state_op;
      logic         done;
      seq_type      seq;
      upc_type      target;
   } ctrl_word_type;

   // control store
   function automatic ctrl_word_type ucode_rom(input upc_type pc);
      ctrl_word_type cw;
      cw = '{busy: 1'b1, ram_op: RAM_NONE, cnt_step: 1'b0, state_op: ST_HOLD,
             done: 1'b0, seq: SEQ_GOTO, target: UPC_IDLE};
      unique case (pc)
         UPC_CLEAR: begin
            cw.ram_op   = RAM_CLEAR;
            cw.cnt_step = 1'b1;
            cw.seq      = SEQ_LOOP;
            cw.target   = UPC_IDLE;
         end
         UPC_IDLE: begin
            cw.busy   = 1'b0;
            cw.seq    = SEQ_DISPATCH;
            cw.target = UPC_IDLE;
         end
         UPC_WR_RD: begin
            cw.ram_op = RAM_READ_DST;
            cw.target = UPC_WR_MOD;
         end
         UPC_WR_MOD: begin
            cw.ram_op = RAM_MERGE;
            cw.done   = 1'b1;
         end
         UPC_LOAD: begin
            cw.state_op = ST_LOAD;
            cw.done     = 1'b1;
         end
         UPC_REPLY: begin
            cw.done = 1'b1;
         end
         UPC_STEP: begin
            cw.ram_op   = RAM_READ_CNT;
            cw.cnt_step = 1'b1;
            cw.seq      = SEQ_LOOP;
            cw.target   = UPC_DRAIN_A;
         end
         UPC_DRAIN_A: begin
            cw.target = UPC_DRAIN_B;
         end
         UPC_DRAIN_B: begin
            cw.target = UPC_COMMIT;
         end
         UPC_COMMIT: begin
            cw.state_op = ST_COMMIT;
            cw.done     = 1'b1;
         end
         default: begin
            cw.target = UPC_IDLE;
         end
      endcase
      return cw;
   endfunction

   // entry point of each request
   function automatic upc_type dispatch(input logic [REQ_W-1:0] code);
      upc_type pc;
      unique case (code)
         REQ_WRITE: pc = UPC_WR_RD;
         REQ_LOAD:  pc = UPC_LOAD;
         REQ_STEP:  pc = UPC_STEP;
         default:   pc = UPC_REPLY;
      endcase
      return pc;
   endfunction

endpackage

// ===== sv/tnsu_ram.sv =====
module tnsu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/threshold_network_sync_update.sv =====
// Synchronous threshold network over tnsu_pkg::NODES nodes with -1/0/+1 edge weights.
// Every accepted item (start high while busy low) gives exactly one result: a one-cycle
// rsp_done strobe with the node state vector after the item. The receiver cannot stall,
// so rsp_state_vector must be captured in the strobe cycle. A weight write is a
// read-modify-write of one weight row. A step is run by the microprogram reading one
// destination node's weight row per cycle from the weight RAM, followed by a two-stage
// count and compare pipeline, so NODES sets its length. After reset the weight RAM is
// cleared one row per cycle with busy high; csr writes to fire_threshold are taken at
// any time but are meant for idle periods.
module threshold_network_sync_update (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [tnsu_pkg::REQ_W-1:0]        req_type,
   input  logic [tnsu_pkg::NODE_W-1:0]       req_src_node,
   input  logic [tnsu_pkg::NODE_W-1:0]       req_dst_node,
   input  logic signed [tnsu_pkg::WEIGHT_W-1:0] req_edge_weight,
   input  logic [tnsu_pkg::STATE_W-1:0]      req_state_load,
   input  logic                              csr_write_en,
   input  logic signed [tnsu_pkg::THR_W-1:0] csr_write_data,
   output logic                              rsp_done,
   output logic [tnsu_pkg::STATE_W-1:0]      rsp_state_vector
);

   // sequencer
   tnsu_pkg::upc_type                      pc_ff, pc_in;
   tnsu_pkg::ctrl_word_type                cw;
   logic [tnsu_pkg::NODE_IDX_W-1:0]        cnt_ff, cnt_in;
   logic                                   cnt_last;

   // request and configuration registers
   logic [tnsu_pkg::NODE_W-1:0]            src_ff, dst_ff;
   logic [tnsu_pkg::WEIGHT_W-1:0]          weight_ff;
   logic [tnsu_pkg::STATE_W-1:0]           load_ff;
   logic signed [tnsu_pkg::THR_W-1:0]      thr_ff;
   logic                                   accept;

   // node state
   logic [tnsu_pkg::STATE_W-1:0]           state_ff, state_in;
   logic [tnsu_pkg::NODES-1:0]             next_ff, next_in;

   // weight ram
   logic                                   ram_we, ram_re;
   logic [tnsu_pkg::NODE_IDX_W-1:0]        ram_waddr, ram_raddr;
   logic [tnsu_pkg::ROW_W-1:0]             ram_wdata, ram_rdata, merged_row;
   logic                                   in_range;

   // step pipeline
   logic                                   p1_valid_ff;
   logic [tnsu_pkg::NODE_IDX_W-1:0]        p1_idx_ff;
   logic                                   p2_valid_ff;
   logic [tnsu_pkg::NODE_IDX_W-1:0]        p2_idx_ff;
   logic [tnsu_pkg::GRP_CNT_W-1:0]         grp_pos_ff [tnsu_pkg::GROUPS];
   logic [tnsu_pkg::GRP_CNT_W-1:0]         grp_neg_ff [tnsu_pkg::GROUPS];
   logic [tnsu_pkg::GRP_CNT_W-1:0]         grp_pos_in [tnsu_pkg::GROUPS];
   logic [tnsu_pkg::GRP_CNT_W-1:0]         grp_neg_in [tnsu_pkg::GROUPS];
   logic [tnsu_pkg::CNT_W-1:0]             pos_sum, neg_sum;
   logic signed [tnsu_pkg::CMP_W-1:0]      net_sum, thr_ext;
   logic                                   node_bit;

   // result register
   logic                                   rsp_done_ff;
   logic [tnsu_pkg::STATE_W-1:0]           rsp_state_ff;

   assign cw       = tnsu_pkg::ucode_rom(pc_ff);
   assign busy     = cw.busy;
   assign accept   = start && !cw.busy;
   assign cnt_last = (cnt_ff == tnsu_pkg::LAST_NODE);

   // next microprogram address
   always_comb begin
      unique case (cw.seq)
         tnsu_pkg::SEQ_GOTO:     pc_in = cw.target;
         tnsu_pkg::SEQ_LOOP:     pc_in = cnt_last ? cw.target : pc_ff;
         tnsu_pkg::SEQ_DISPATCH: pc_in = start ? tnsu_pkg::dispatch(req_type) : pc_ff;
         default:                pc_in = tnsu_pkg::UPC_IDLE;
      endcase
   end

   // row counter, wraps to zero after the last node
   always_comb begin
      cnt_in = cnt_ff;
      if (cw.cnt_step) begin
         cnt_in = cnt_last ? '0 : cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= tnsu_pkg::UPC_CLEAR;
         cnt_ff <= '0;
      end else begin
         pc_ff  <= pc_in;
         cnt_ff <= cnt_in;
      end
   end

   // capture request on transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         src_ff    <= req_src_node;
         dst_ff    <= req_dst_node;
         weight_ff <= (req_edge_weight == tnsu_pkg::W_NEG_SAT) ? tnsu_pkg::W_MINUS
                                                               : req_edge_weight;
         load_ff   <= req_state_load;
      end
   end

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_write_en) begin
         thr_ff <= csr_write_data;
      end
   end

   // weight row merge
   assign in_range = ({1'b0, src_ff} < (tnsu_pkg::NODE_W + 1)'(tnsu_pkg::NODES)) &&
                     ({1'b0, dst_ff} < (tnsu_pkg::NODE_W + 1)'(tnsu_pkg::NODES));

   always_comb begin
      merged_row = ram_rdata;
      merged_row[{src_ff, 1'b0} +: tnsu_pkg::WEIGHT_W] = weight_ff;
   end

   // ram control decode
   always_comb begin
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_waddr = dst_ff[tnsu_pkg::NODE_IDX_W-1:0];
      ram_raddr = dst_ff[tnsu_pkg::NODE_IDX_W-1:0];
      ram_wdata = merged_row;
      unique case (cw.ram_op)
         tnsu_pkg::RAM_NONE: begin
         end
         tnsu_pkg::RAM_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_ff;
            ram_wdata = '0;
         end
         tnsu_pkg::RAM_READ_DST: begin
            ram_re = 1'b1;
         end
         tnsu_pkg::RAM_MERGE: begin
            ram_we = in_range;
         end
         tnsu_pkg::RAM_READ_CNT: begin
            ram_re    = 1'b1;
            ram_raddr = cnt_ff;
         end
         default: begin
         end
      endcase
   end

   tnsu_ram #(
      .WIDTH (tnsu_pkg::ROW_W),
      .DEPTH (tnsu_pkg::NODES)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // step pipeline valid and node index
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= (cw.ram_op == tnsu_pkg::RAM_READ_CNT);
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_idx_ff <= cnt_ff;
      p2_idx_ff <= p1_idx_ff;
   end

   // stage a: per-group counts of active +1 and -1 sources
   always_comb begin
      int idx;
      for (int g = 0; g < tnsu_pkg::GROUPS; g++) begin
         grp_pos_in[g] = '0;
         grp_neg_in[g] = '0;
         for (int b = 0; b < tnsu_pkg::GRP; b++) begin
            idx = g * tnsu_pkg::GRP + b;
            if (idx < tnsu_pkg::NODES) begin
               grp_pos_in[g] = grp_pos_in[g] + tnsu_pkg::GRP_CNT_W'(
                  ram_rdata[2*idx] & ~ram_rdata[2*idx+1] & state_ff[idx]);
               grp_neg_in[g] = grp_neg_in[g] + tnsu_pkg::GRP_CNT_W'(
                  ram_rdata[2*idx+1] & state_ff[idx]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < tnsu_pkg::GROUPS; g++) begin
         grp_pos_ff[g] <= grp_pos_in[g];
         grp_neg_ff[g] <= grp_neg_in[g];
      end
   end

   // stage b: net sum against threshold, a tie keeps the old bit
   always_comb begin
      pos_sum = '0;
      neg_sum = '0;
      for (int g = 0; g < tnsu_pkg::GROUPS; g++) begin
         pos_sum = pos_sum + tnsu_pkg::CNT_W'(grp_pos_ff[g]);
         neg_sum = neg_sum + tnsu_pkg::CNT_W'(grp_neg_ff[g]);
      end
      net_sum = $signed(tnsu_pkg::CMP_W'(pos_sum)) - $signed(tnsu_pkg::CMP_W'(neg_sum));
      thr_ext = tnsu_pkg::CMP_W'(thr_ff);
      if (net_sum == thr_ext) begin
         node_bit = state_ff[p2_idx_ff];
      end else begin
         node_bit = (net_sum > thr_ext);
      end
   end

   always_comb begin
      next_in = next_ff;
      if (p2_valid_ff) begin
         next_in[p2_idx_ff] = node_bit;
      end
   end

   always_ff @(posedge clock) begin
      next_ff <= next_in;
   end

   // node state update
   always_comb begin
      unique case (cw.state_op)
         tnsu_pkg::ST_HOLD:   state_in = state_ff;
         tnsu_pkg::ST_LOAD:   state_in = load_ff & tnsu_pkg::NODE_MASK;
         tnsu_pkg::ST_COMMIT: state_in = tnsu_pkg::STATE_W'(next_ff);
         default:             state_in = state_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_done_ff <= 1'b0;
      end else begin
         rsp_done_ff <= cw.done;
      end
   end

   always_ff @(posedge clock) begin
      if (cw.done) begin
         rsp_state_ff <= state_in;
      end
   end

   assign rsp_done         = rsp_done_ff;
   assign rsp_state_vector = rsp_state_ff;

endmodule

// ===== sv/tnsu_checker.sv =====
`include "threshold_network_sync_update_defines.svh"

module tnsu_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic [tnsu_pkg::REQ_W-1:0]         req_type,
   input logic [tnsu_pkg::STATE_W-1:0]       req_state_load,
   input logic                               rsp_done,
   input logic [tnsu_pkg::STATE_W-1:0]       rsp_state_vector
);

   // a transfer always takes the block out of idle
   `TNSU_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

   // one strobe per item, never two in a row
   `TNSU_ASSERT_NEXT(a_single_strobe, rsp_done, !rsp_done)

   // a result appears only once the block is idle again
   `TNSU_ASSERT_NOW(a_done_idle, rsp_done, !busy)

   // a load is answered, through the LOAD state and the result register, with the loaded vector
   `TNSU_ASSERT_AFTER2(a_load_result,
      start && !busy && (req_type == tnsu_pkg::REQ_LOAD),
      rsp_done && (rsp_state_vector == ($past(req_state_load, 2) & tnsu_pkg::NODE_MASK)))

endmodule

bind threshold_network_sync_update tnsu_checker u_tnsu_checker (.*);
